// File: sv/gmx_pkg.sv
// ----------------------------------------------------------------------------
// gmx_pkg: shared types and constants for the G1 move coordinate extractor
// Character codes, payload types and the decimal scale table.
// ----------------------------------------------------------------------------
package gmx_pkg;

    typedef logic [7:0]         t_char;
    typedef logic signed [31:0] t_pos;

    localparam t_char CH_LF    = 8'd10;
    localparam t_char CH_TAB   = 8'd9;
    localparam t_char CH_VT    = 8'd11;
    localparam t_char CH_FF    = 8'd12;
    localparam t_char CH_CR    = 8'd13;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_POINT = 8'h2E;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_ONE   = 8'h31;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_G     = 8'h47;
    localparam t_char CH_X     = 8'h58;
    localparam t_char CH_Y     = 8'h59;

    // Place value of a digit, 10^k for k in 0..6
    function automatic logic [23:0] pow10(input logic [2:0] k);
        logic [23:0] p;
        case (k)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            default: p = 24'd1000000;
        endcase
        return p;
    endfunction

endpackage

// File: sv/gmx_char_if.sv
// ----------------------------------------------------------------------------
// gmx_char_if: text byte channel
// Valid/ready channel carrying one G-code character per transaction.
// ----------------------------------------------------------------------------
interface gmx_char_if;
    logic           valid;
    logic           ready;
    gmx_pkg::t_char char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// File: sv/gmx_pos_if.sv
// ----------------------------------------------------------------------------
// gmx_pos_if: coordinate channel
// Valid/ready channel carrying one X/Y position pair per transaction.
// ----------------------------------------------------------------------------
interface gmx_pos_if;
    logic          valid;
    logic          ready;
    gmx_pkg::t_pos x_pos;
    gmx_pkg::t_pos y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

// File: sv/gcode_move_xy_extractor.sv
// ----------------------------------------------------------------------------
// gcode_move_xy_extractor: G1 move X/Y coordinate extractor
// Throughput: one character per cycle while the result register is free or
// being drained; the per-byte update is at most a scale by ten, an add and a compare per axis.
// The X/Y pair appears on o_pos in the cycle after the newline that ends
// a G1 line is accepted. Reset (synchronous, active low) clears the line
// state and sets both held coordinates to zero.
// ----------------------------------------------------------------------------
module gcode_move_xy_extractor #(
    parameter int FRAC_DIGITS = 3,
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gmx_char_if.sink   i_char,
    gmx_pos_if.source  o_pos
);

    localparam int W  = VALUE_WIDTH;
    localparam int EW = ((W > 28) ? W : 28) + 5;
    localparam int NAX = 2;

    typedef enum logic [1:0] {PH_WAIT, PH_START, PH_NUM, PH_DONE} t_phase;

    // Line state
    logic [1:0]          r_char_count, n_char_count;
    logic                r_move_line,  n_move_line;

    // Per-axis state; the accumulator holds the magnitude already scaled to
    // the fixed-point unit, saturated at the cap
    t_phase              r_phase [NAX];
    t_phase              n_phase [NAX];
    logic [W-1:0]        r_acc   [NAX];
    logic [W-1:0]        n_acc   [NAX];
    logic [2:0]          r_frac  [NAX];
    logic [2:0]          n_frac  [NAX];
    logic                r_neg   [NAX];
    logic                n_neg   [NAX];
    logic signed [W-1:0] r_last  [NAX];
    logic signed [W-1:0] n_last  [NAX];

    logic                r_out_valid;
    gmx_pkg::t_pos       r_x_pos;
    gmx_pkg::t_pos       r_y_pos;

    logic                accept;
    logic                is_lf;
    logic                emit;
    gmx_pkg::t_char      c;

    assign c       = i_char.char_in;
    assign accept  = i_char.valid && i_char.ready;
    assign is_lf   = (c == gmx_pkg::CH_LF);
    assign emit    = accept && is_lf && (r_char_count == 2'd2) && r_move_line;

    assign i_char.ready = !r_out_valid || o_pos.ready;
    assign o_pos.valid  = r_out_valid;
    assign o_pos.x_pos  = r_x_pos;
    assign o_pos.y_pos  = r_y_pos;

    always_comb begin
        n_char_count = r_char_count;
        n_move_line  = r_move_line;
        if (is_lf) begin
            n_char_count = 2'd0;
            n_move_line  = 1'b0;
        end else if (r_char_count == 2'd0) begin
            n_move_line  = (c == gmx_pkg::CH_G);
            n_char_count = 2'd1;
        end else if (r_char_count == 2'd1) begin
            n_move_line  = r_move_line && (c == gmx_pkg::CH_ONE);
            n_char_count = 2'd2;
        end
    end

    for (genvar a = 0; a < NAX; a++) begin : g_axis
        gmx_pkg::t_char letter;
        logic           is_digit;
        logic           is_ws;
        logic [3:0]     digit;
        logic [2:0]     place;
        logic [27:0]    addend;
        logic [EW-1:0]  base;
        logic [EW-1:0]  sum;
        logic [W-1:0]   cap;
        logic [W-1:0]   sat_acc;
        logic           take_digit;

        assign letter   = (a == 0) ? gmx_pkg::CH_X : gmx_pkg::CH_Y;
        assign is_digit = (c >= gmx_pkg::CH_ZERO) && (c <= gmx_pkg::CH_NINE);
        assign is_ws    = (c == gmx_pkg::CH_TAB) || (c == gmx_pkg::CH_VT) ||
                          (c == gmx_pkg::CH_FF)  || (c == gmx_pkg::CH_CR);
        assign digit    = 4'(c - gmx_pkg::CH_ZERO);
        assign cap      = {1'b0, {(W-1){1'b1}}} + W'(r_neg[a]);

        // Integer digit: acc*10 + d*10^F; fraction digit j: acc + d*10^(F-j)
        assign place      = (r_frac[a] == 3'd0) ? 3'(FRAC_DIGITS)
                                                : 3'(FRAC_DIGITS - int'(r_frac[a]));
        assign take_digit = (r_frac[a] == 3'd0) || (int'(r_frac[a]) <= FRAC_DIGITS);
        assign addend     = 28'(digit * gmx_pkg::pow10(place));
        assign base       = (r_frac[a] == 3'd0)
                            ? ((EW'(r_acc[a]) << 3) + (EW'(r_acc[a]) << 1))
                            : EW'(r_acc[a]);
        assign sum        = base + EW'(addend);
        assign sat_acc    = (sum > EW'(cap)) ? cap : sum[W-1:0];

        always_comb begin
            n_phase[a] = r_phase[a];
            n_acc[a]   = r_acc[a];
            n_frac[a]  = r_frac[a];
            n_neg[a]   = r_neg[a];
            n_last[a]  = r_last[a];
            if (is_lf) begin
                if (emit && r_phase[a] != PH_WAIT) begin
                    n_last[a] = r_neg[a] ? signed'(W'(0) - r_acc[a]) : signed'(r_acc[a]);
                end
                n_phase[a] = PH_WAIT;
                n_acc[a]   = '0;
                n_frac[a]  = 3'd0;
                n_neg[a]   = 1'b0;
            end else begin
                unique case (r_phase[a])
                    PH_WAIT: begin
                        if (c == letter) begin
                            n_phase[a] = PH_START;
                            n_acc[a]   = '0;
                            n_frac[a]  = 3'd0;
                            n_neg[a]   = 1'b0;
                        end
                    end
                    PH_START, PH_NUM: begin
                        if (c == gmx_pkg::CH_SPACE) begin
                            n_phase[a] = PH_DONE;
                        end else if (r_phase[a] == PH_START && is_ws) begin
                            n_phase[a] = PH_START;
                        end else if (r_phase[a] == PH_START && c == gmx_pkg::CH_PLUS) begin
                            n_phase[a] = PH_NUM;
                        end else if (r_phase[a] == PH_START && c == gmx_pkg::CH_MINUS) begin
                            n_phase[a] = PH_NUM;
                            n_neg[a]   = 1'b1;
                        end else begin
                            n_phase[a] = PH_NUM;
                            if (is_digit) begin
                                // drop digits beyond the kept fraction
                                if (take_digit) begin
                                    n_acc[a] = sat_acc;
                                    if (r_frac[a] != 3'd0) begin
                                        n_frac[a] = r_frac[a] + 3'd1;
                                    end
                                end
                            end else if (c == gmx_pkg::CH_POINT && r_frac[a] == 3'd0) begin
                                n_frac[a] = 3'd1;
                            end else begin
                                n_phase[a] = PH_DONE;
                            end
                        end
                    end
                    default: begin
                        n_phase[a] = PH_DONE;
                    end
                endcase
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_phase[a] <= PH_WAIT;
                r_acc[a]   <= '0;
                r_frac[a]  <= 3'd0;
                r_neg[a]   <= 1'b0;
                r_last[a]  <= '0;
            end else if (accept) begin
                r_phase[a] <= n_phase[a];
                r_acc[a]   <= n_acc[a];
                r_frac[a]  <= n_frac[a];
                r_neg[a]   <= n_neg[a];
                r_last[a]  <= n_last[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= 2'd0;
            r_move_line  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_char_count <= n_char_count;
                r_move_line  <= n_move_line;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pos.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; sign-extend or truncate the held value to the port width
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_x_pos <= 32'(n_last[0]);
            r_y_pos <= 32'(n_last[1]);
        end
    end

endmodule
